>>> rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
// Used by i2cm_step and i2c_master_bit_engine; no dependencies.
package i2cm_pkg;

    localparam int unsigned TICK_W     = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned BIT_IDX_W  = 4;
    localparam int unsigned PHASE_W    = 2;

    localparam logic [BIT_IDX_W-1:0] BYTE_BITS        = 4'd8;
    localparam logic [TICK_W-1:0]    PHASE_TICKS_INIT = 16'd56;

    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_ACK   = 3'd4,
        CMD_NACK  = 3'd5
    } t_cmd;

    typedef struct packed {
        t_cmd                  cmd;
        logic [PHASE_W-1:0]    phase;
        logic [BIT_IDX_W-1:0]  bit_idx;
        logic [TICK_W-1:0]     tick;
        logic [BYTE_W-1:0]     shift;
        logic                  scl;
        logic                  sda;
        logic                  ack;
        logic                  busy;
        logic [BYTE_W-1:0]     rx_hold;
    } t_state;

    localparam t_state STATE_INIT = '{
        cmd:     CMD_START,
        phase:   '0,
        bit_idx: '0,
        tick:    '0,
        shift:   '0,
        scl:     1'b1,
        sda:     1'b1,
        ack:     1'b0,
        busy:    1'b0,
        rx_hold: '0
    };

endpackage

>>> rtl/i2cm_step.sv
// One tick of the I2C pin sequencer: next state from current state and inputs.
// Depends on i2cm_pkg for the state struct and command codes.
module i2cm_step (
    input  i2cm_pkg::t_state                 i_cur,
    input  logic [i2cm_pkg::TICK_W-1:0]      i_phase_ticks,
    input  logic                             i_cmd_valid,
    input  logic [2:0]                       i_cmd,
    input  logic [i2cm_pkg::BYTE_W-1:0]      i_tx_byte,
    input  logic                             i_sda_in,
    output i2cm_pkg::t_state                 o_nxt,
    output logic                             o_done
);
    import i2cm_pkg::*;

    // Apply the pin levels of the phase the state now points at.
    function automatic t_state enter_phase(input t_state s);
        t_state r;
        r = s;
        unique case (s.cmd)
            CMD_START: begin
                if (s.phase == 2'd0) begin
                    r.sda = 1'b1;
                    r.scl = 1'b1;
                end else if (s.phase == 2'd1) begin
                    r.sda = 1'b0;
                end else begin
                    r.scl = 1'b0;
                end
            end
            CMD_STOP: begin
                if (s.phase == 2'd0) r.sda = 1'b0;
                else if (s.phase == 2'd1) r.scl = 1'b1;
                else r.sda = 1'b1;
            end
            CMD_WRITE: begin
                if (s.bit_idx < BYTE_BITS) begin
                    if (s.phase == 2'd0) begin
                        r.sda   = s.shift[BYTE_W-1];
                        r.shift = {s.shift[BYTE_W-2:0], 1'b0};
                    end else if (s.phase == 2'd1) begin
                        r.scl = 1'b1;
                    end else begin
                        r.scl = 1'b0;
                    end
                end else if (s.phase == 2'd0) begin
                    // release SDA for the acknowledge
                    r.sda = 1'b1;
                    r.scl = 1'b1;
                end else begin
                    r.scl = 1'b0;
                end
            end
            CMD_READ: begin
                if (s.phase == 2'd0) r.sda = 1'b1;
                else if (s.phase == 2'd1) r.scl = 1'b1;
                else r.scl = 1'b0;
            end
            default: begin
                if (s.phase == 2'd0) begin
                    r.sda = (s.cmd == CMD_ACK) ? 1'b0 : 1'b1;
                    r.scl = 1'b1;
                end else begin
                    r.scl = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    logic [TICK_W-1:0] limit;
    logic [TICK_W-1:0] tick_inc;
    t_state            left;
    logic              finish;

    assign limit    = (i_phase_ticks == '0) ? TICK_W'(1) : i_phase_ticks;
    assign tick_inc = i_cur.tick + TICK_W'(1);

    // End of the current phase: sample SDA and advance phase and bit.
    always_comb begin
        left   = i_cur;
        finish = 1'b0;
        left.tick = '0;
        unique case (i_cur.cmd)
            CMD_START, CMD_STOP: begin
                finish     = (i_cur.phase == 2'd2);
                left.phase = finish ? 2'd0 : i_cur.phase + 2'd1;
            end
            CMD_WRITE: begin
                if (i_cur.bit_idx < BYTE_BITS) begin
                    if (i_cur.phase == 2'd2) begin
                        left.phase   = 2'd0;
                        left.bit_idx = i_cur.bit_idx + BIT_IDX_W'(1);
                    end else begin
                        left.phase = i_cur.phase + 2'd1;
                    end
                end else begin
                    if (i_cur.phase == 2'd0) left.ack = ~i_sda_in;
                    finish     = (i_cur.phase == 2'd1);
                    left.phase = finish ? 2'd0 : i_cur.phase + 2'd1;
                end
            end
            CMD_READ: begin
                if (i_cur.phase == 2'd1) left.shift = {i_cur.shift[BYTE_W-2:0], i_sda_in};
                if (i_cur.phase == 2'd2) begin
                    left.phase   = 2'd0;
                    left.bit_idx = i_cur.bit_idx + BIT_IDX_W'(1);
                    if (left.bit_idx >= BYTE_BITS) begin
                        finish       = 1'b1;
                        left.rx_hold = i_cur.shift;
                    end
                end else begin
                    left.phase = i_cur.phase + 2'd1;
                end
            end
            default: begin
                finish     = (i_cur.phase == 2'd1);
                left.phase = finish ? 2'd0 : i_cur.phase + 2'd1;
            end
        endcase
    end

    always_comb begin
        t_state start;
        start  = i_cur;
        o_nxt  = i_cur;
        o_done = 1'b0;
        if (i_cur.busy) begin
            if (tick_inc >= limit) begin
                if (finish) begin
                    o_nxt      = left;
                    o_nxt.busy = 1'b0;
                    o_done     = 1'b1;
                end else begin
                    o_nxt = enter_phase(left);
                end
            end else begin
                o_nxt.tick = tick_inc;
            end
        end else if (i_cmd_valid && i_cmd <= CMD_NACK) begin
            start.cmd     = t_cmd'(i_cmd);
            start.phase   = '0;
            start.bit_idx = '0;
            start.tick    = '0;
            if (i_cmd == CMD_WRITE) start.shift = i_tx_byte;
            else if (i_cmd == CMD_READ) start.shift = '0;
            start.busy = 1'b1;
            o_nxt = enter_phase(start);
        end
    end

endmodule

>>> rtl/i2c_master_bit_engine.sv
// I2C master bit engine: one tick word in, one pin/status word out per cycle unless stalled.
// The result word of an accepted tick word is in the output register in the next cycle.
// Throughput: one word per cycle when not stalled; the state update is a single pass through i2cm_step.
// Input stalls only while the output register holds a word that is itself stalled.
// Reset (synchronous, active low): lines released, idle, phase_ticks 56, output empty.
// Depends on i2cm_pkg and i2cm_step.
module i2c_master_bit_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd_valid,
    input  logic [2:0]                    i_cmd,
    input  logic [i2cm_pkg::BYTE_W-1:0]   i_tx_byte,
    input  logic                          i_sda_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_scl_out,
    output logic                          o_sda_out,
    output logic                          o_busy_res,
    output logic                          o_done_res,
    output logic [i2cm_pkg::BYTE_W-1:0]   o_rx_byte,
    output logic                          o_ack_received,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [i2cm_pkg::TICK_W-1:0]   i_cfg_data
);
    import i2cm_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic              n_done;
    logic [TICK_W-1:0] r_phase_ticks;
    logic              r_out_valid;
    logic              r_done;
    logic              in_accept;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    i2cm_step u_step (
        .i_cur         (r_state),
        .i_phase_ticks (r_phase_ticks),
        .i_cmd_valid   (i_cmd_valid),
        .i_cmd         (i_cmd),
        .i_tx_byte     (i_tx_byte),
        .i_sda_in      (i_sda_in),
        .o_nxt         (n_state),
        .o_done        (n_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= STATE_INIT;
            r_phase_ticks <= PHASE_TICKS_INIT;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) r_phase_ticks <= i_cfg_data;
            if (in_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word: load with the step result, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_done <= n_done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scl_out      = r_state.scl;
    assign o_sda_out      = r_state.sda;
    assign o_busy_res     = r_state.busy;
    assign o_done_res     = r_done;
    assign o_rx_byte      = r_state.rx_hold;
    assign o_ack_received = r_state.ack;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted word produced no result");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.busy |-> r_state.bit_idx <= BYTE_BITS)
        else $error("bit index beyond byte length");

    a_tick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.busy |-> r_state.tick == '0)
        else $error("tick counter running while idle");

endmodule

>>> verif/tb_i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench for i2c_master_bit_engine: drives tick words, predicts pin words.
// Depends on i2cm_pkg and the RTL of i2c_master_bit_engine.
module tb_i2c_master_bit_engine;
    import i2cm_pkg::*;

    localparam logic [2:0] CMD_BAD_LO  = 3'd6;
    localparam logic [2:0] CMD_BAD_HI  = 3'd7;
    localparam int         HOLD_CYCLES = 64;
    localparam int         STUCK_LIMIT = 1000;
    localparam int         PRINT_CAP   = 100;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rx;
        logic              ack;
    } t_pin_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_cmd_valid;
    logic [2:0]        i_cmd;
    logic [BYTE_W-1:0] i_tx_byte;
    logic              i_sda_in;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_scl_out;
    logic              o_sda_out;
    logic              o_busy_res;
    logic              o_done_res;
    logic [BYTE_W-1:0] o_rx_byte;
    logic              o_ack_received;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [TICK_W-1:0] i_cfg_data;

    // predicted sequencer state
    logic [TICK_W-1:0]    hold_ticks;
    t_cmd                 cur_cmd;
    logic [2:0]           ph;
    logic [BIT_IDX_W-1:0] bitn;
    logic [TICK_W-1:0]    tcnt;
    logic [BYTE_W-1:0]    shreg;
    logic [BYTE_W-1:0]    rx_q;
    logic                 scl_q;
    logic                 sda_q;
    logic                 ack_q;
    logic                 busy_q;

    t_pin_word pin_words_due[$];
    int        errors        = 0;
    int        ticks_sent    = 0;
    int        gap_pct       = 0;
    int        out_stall_pct = 0;
    int        stuck_cycles  = 0;
    logic      quiet         = 1'b0;
    logic      long_hold     = 1'b0;

    i2c_master_bit_engine u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd_valid    (i_cmd_valid),
        .i_cmd          (i_cmd),
        .i_tx_byte      (i_tx_byte),
        .i_sda_in       (i_sda_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_scl_out      (o_scl_out),
        .o_sda_out      (o_sda_out),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_rx_byte      (o_rx_byte),
        .o_ack_received (o_ack_received),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Drive the pins for the first tick of the current phase.
    function automatic void apply_phase();
        case (cur_cmd)
            CMD_START: begin
                if (ph == 0) begin
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                end else if (ph == 1) sda_q = 1'b0;
                else scl_q = 1'b0;
            end
            CMD_STOP: begin
                if (ph == 0) sda_q = 1'b0;
                else if (ph == 1) scl_q = 1'b1;
                else sda_q = 1'b1;
            end
            CMD_WRITE: begin
                if (bitn < BYTE_BITS) begin
                    if (ph == 0) begin
                        sda_q = shreg[BYTE_W-1];
                        shreg = shreg << 1;
                    end else if (ph == 1) scl_q = 1'b1;
                    else scl_q = 1'b0;
                end else if (ph == 0) begin
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                end else scl_q = 1'b0;
            end
            CMD_READ: begin
                if (ph == 0) sda_q = 1'b1;
                else if (ph == 1) scl_q = 1'b1;
                else scl_q = 1'b0;
            end
            default: begin
                if (ph == 0) begin
                    sda_q = (cur_cmd == CMD_ACK) ? 1'b0 : 1'b1;
                    scl_q = 1'b1;
                end else scl_q = 1'b0;
            end
        endcase
    endfunction

    // Advance the sequencer by one tick and return the pin word it shows.
    function automatic t_pin_word tick_sequencer(input logic cv, input logic [2:0] cmd,
                                                 input logic [BYTE_W-1:0] tx, input logic sda);
        logic [TICK_W-1:0] lim;
        logic              cmd_done;
        t_pin_word         w;
        lim      = (hold_ticks == 0) ? TICK_W'(1) : hold_ticks;
        cmd_done = 1'b0;
        if (busy_q) begin
            tcnt = tcnt + TICK_W'(1);
            if (tcnt >= lim) begin
                tcnt = '0;
                case (cur_cmd)
                    CMD_START, CMD_STOP: begin
                        ph++;
                        cmd_done = (ph >= 3);
                    end
                    CMD_WRITE: begin
                        if (bitn < BYTE_BITS) begin
                            ph++;
                            if (ph >= 3) begin
                                ph = '0;
                                bitn++;
                            end
                        end else begin
                            // ack is sampled at the end of the released SCL-high phase
                            if (ph == 0) ack_q = ~sda;
                            ph++;
                            cmd_done = (ph >= 2);
                        end
                    end
                    CMD_READ: begin
                        if (ph == 1) shreg = {shreg[BYTE_W-2:0], sda};
                        ph++;
                        if (ph >= 3) begin
                            ph = '0;
                            bitn++;
                            if (bitn >= BYTE_BITS) begin
                                rx_q     = shreg;
                                cmd_done = 1'b1;
                            end
                        end
                    end
                    default: begin
                        ph++;
                        cmd_done = (ph >= 2);
                    end
                endcase
                if (cmd_done) busy_q = 1'b0;
                else apply_phase();
            end
        end else if (cv && cmd <= CMD_NACK) begin
            cur_cmd = t_cmd'(cmd);
            ph      = '0;
            bitn    = '0;
            tcnt    = '0;
            if (cmd == CMD_WRITE) shreg = tx;
            else if (cmd == CMD_READ) shreg = '0;
            busy_q = 1'b1;
            apply_phase();
        end
        w.scl  = scl_q;
        w.sda  = sda_q;
        w.busy = busy_q;
        w.done = cmd_done;
        w.rx   = rx_q;
        w.ack  = ack_q;
        return w;
    endfunction

    function automatic logic pick_sda(input int sda_mode);
        return (sda_mode > 1) ? 1'($urandom_range(1)) : 1'(sda_mode);
    endfunction

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= PRINT_CAP)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Offer one tick word and hold it until accepted, then log its prediction.
    task automatic send_tick(input logic cv, input logic [2:0] cmd,
                             input logic [BYTE_W-1:0] tx, input logic sda);
        if (!quiet && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd_valid <= cv;
        i_cmd       <= cmd;
        i_tx_byte   <= tx;
        i_sda_in    <= sda;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pin_words_due.push_back(tick_sequencer(cv, cmd, tx, sda));
        ticks_sent++;
    endtask

    // Tick until the command in flight completes; stray commands meanwhile are ignored.
    task automatic finish_command(input int sda_mode);
        while (busy_q)
            send_tick(1'($urandom_range(1)), 3'($urandom_range(7)), BYTE_W'($urandom),
                      pick_sda(sda_mode));
    endtask

    task automatic run_command(input t_cmd cmd, input logic [BYTE_W-1:0] tx, input int sda_mode);
        send_tick(1'b1, cmd, tx, pick_sda(sda_mode));
        finish_command(sda_mode);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pin_words_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_phase_ticks(input logic [TICK_W-1:0] value);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        hold_ticks = value;
    endtask

    task automatic test_idle_after_reset();
        repeat (3) send_tick(1'b0, CMD_STOP, 8'hFF, 1'b0);
        // reserved codes must leave the sequencer idle
        send_tick(1'b1, CMD_BAD_LO, 8'h00, 1'b1);
        send_tick(1'b1, CMD_BAD_HI, 8'hFF, 1'b0);
    endtask

    task automatic test_every_command();
        gap_pct       = 20;
        out_stall_pct = 20;
        write_phase_ticks(16'd1);
        run_command(CMD_START, 8'h00, 2);
        run_command(CMD_WRITE, 8'hFF, 0);
        run_command(CMD_WRITE, 8'h00, 1);
        run_command(CMD_READ, 8'h00, 2);
        run_command(CMD_ACK, 8'h00, 2);
        run_command(CMD_READ, 8'hA5, 1);
        run_command(CMD_NACK, 8'h00, 2);
        run_command(CMD_STOP, 8'h00, 2);
    endtask

    task automatic test_phase_ticks_extremes();
        write_phase_ticks(16'd0);
        run_command(CMD_START, 8'h00, 2);
        write_phase_ticks(16'hFFFF);
        send_tick(1'b1, CMD_WRITE, 8'h5A, 1'b0);
        repeat (30) send_tick(1'b0, CMD_READ, 8'h00, 1'($urandom_range(1)));
        // shrink mid-phase: the count is already past the new limit
        write_phase_ticks(16'd2);
        finish_command(0);
        run_command(CMD_STOP, 8'h00, 2);
    endtask

    task automatic test_output_hold();
        gap_pct       = 0;
        out_stall_pct = 0;
        write_phase_ticks(16'd1);
        long_hold = 1'b1;
        run_command(CMD_START, 8'h00, 2);
        run_command(CMD_WRITE, BYTE_W'($urandom), 0);
        wait_drain();
    endtask

    task automatic test_random_transactions();
        int stop_at;
        int quiet_at;
        stop_at  = ticks_sent + 520;
        quiet_at = ticks_sent + 440;
        while (ticks_sent < stop_at) begin
            quiet = (ticks_sent >= quiet_at);
            if (!quiet && $urandom_range(3) == 0) begin
                case ($urandom_range(9))
                    0:       write_phase_ticks(16'd0);
                    1:       write_phase_ticks(TICK_W'($urandom_range(4, 8)));
                    2:       write_phase_ticks(16'd3);
                    3, 4:    write_phase_ticks(16'd2);
                    default: write_phase_ticks(16'd1);
                endcase
            end else if (!quiet && $urandom_range(4) == 0) wait_drain();
            gap_pct       = ($urandom_range(2) == 0) ? 0 : 10 * $urandom_range(1, 4);
            out_stall_pct = ($urandom_range(2) == 0) ? 0 : 10 * $urandom_range(1, 4);
            if ($urandom_range(9) == 0) begin
                // noise, reserved codes and commands out of order
                repeat ($urandom_range(1, 4))
                    send_tick(1'($urandom_range(1)), 3'($urandom_range(7)), BYTE_W'($urandom),
                              1'($urandom_range(1)));
                run_command(t_cmd'($urandom_range(CMD_NACK)), BYTE_W'($urandom), 2);
            end else begin
                run_command(CMD_START, 8'h00, 2);
                repeat ($urandom_range(1, 3))
                    run_command(CMD_WRITE, BYTE_W'($urandom), ($urandom_range(3) != 0) ? 0 : 2);
                if ($urandom_range(1)) begin
                    run_command(CMD_READ, 8'h00, 2);
                    run_command($urandom_range(1) ? CMD_ACK : CMD_NACK, 8'h00, 2);
                end
                run_command(CMD_STOP, 8'h00, 2);
            end
        end
        quiet = 1'b1;
    endtask

    initial begin : receiver
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(99) < out_stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_pin_word want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pin_words_due.size() == 0) begin
                errors++;
                if (errors <= PRINT_CAP)
                    $display("%0t: pin word expected none actual %0h", $time,
                             {o_scl_out, o_sda_out, o_busy_res, o_done_res, o_rx_byte,
                              o_ack_received});
            end else begin
                want = pin_words_due.pop_front();
                check_field("scl_out", BYTE_W'(want.scl), BYTE_W'(o_scl_out));
                check_field("sda_out", BYTE_W'(want.sda), BYTE_W'(o_sda_out));
                check_field("busy_res", BYTE_W'(want.busy), BYTE_W'(o_busy_res));
                check_field("done_res", BYTE_W'(want.done), BYTE_W'(o_done_res));
                check_field("rx_byte", want.rx, o_rx_byte);
                check_field("ack_received", BYTE_W'(want.ack), BYTE_W'(o_ack_received));
            end
        end
    end

    // End the run when no word moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : main
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_cmd_valid = 1'b0;
        i_cmd       = CMD_START;
        i_tx_byte   = '0;
        i_sda_in    = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        hold_ticks  = PHASE_TICKS_INIT;
        cur_cmd     = CMD_START;
        ph          = '0;
        bitn        = '0;
        tcnt        = '0;
        shreg       = '0;
        rx_q        = '0;
        scl_q       = 1'b1;
        sda_q       = 1'b1;
        ack_q       = 1'b0;
        busy_q      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_after_reset();
        test_every_command();
        test_phase_ticks_extremes();
        test_output_hold();
        test_random_transactions();
        wait_drain();
        repeat (4) @(posedge i_clk);
        if (errors == 0 && pin_words_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> i2c_master_bit_engine.f
rtl/i2cm_pkg.sv
rtl/i2cm_step.sv
rtl/i2c_master_bit_engine.sv
verif/tb_i2c_master_bit_engine.sv
